### design/assert_macros.svh
// Assertion helpers for the motor step core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

### design/dcm_pkg.sv
package dcm_pkg;

  localparam int Q_W      = 32;
  localparam int REG_W    = 31;
  localparam int PROD_W   = 64;
  localparam int ACC_W    = 35;
  localparam int PC_W     = 5;
  localparam int DIV_BITS = 7;
  localparam int DIV_STEPS = ACC_W / DIV_BITS;
  localparam int DIV_CNT_W = 3;

  localparam logic [3:0] DIV_BY = 4'd6;

  localparam logic [PC_W-1:0] PC_RK_START = 5'd2;
  localparam logic [PC_W-1:0] PC_LAST     = 5'd28;

  localparam logic [2:0] REG_STEP_SIZE     = 3'd0;
  localparam logic [2:0] REG_RESISTANCE    = 3'd1;
  localparam logic [2:0] REG_INV_INDUCT    = 3'd2;
  localparam logic [2:0] REG_DAMPING       = 3'd3;
  localparam logic [2:0] REG_INV_INERTIA   = 3'd4;
  localparam logic [2:0] REG_TORQUE_CONST  = 3'd5;
  localparam logic [2:0] REG_BACK_EMF      = 3'd6;

  localparam logic [REG_W-1:0] STEP_SIZE_RST    = 31'd66;
  localparam logic [REG_W-1:0] RESISTANCE_RST   = 31'd65536;
  localparam logic [REG_W-1:0] INV_INDUCT_RST   = 31'd65536;
  localparam logic [REG_W-1:0] DAMPING_RST      = 31'd6554;
  localparam logic [REG_W-1:0] INV_INERTIA_RST  = 31'd65536;
  localparam logic [REG_W-1:0] TORQUE_CONST_RST = 31'd65536;
  localparam logic [REG_W-1:0] BACK_EMF_RST     = 31'd65536;

  localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7fff_ffff;
  localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

  typedef logic signed [Q_W-1:0] q_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DIV  = 3'b100
  } state_t;

  typedef enum logic [3:0] {
    OP_MUL,
    OP_VNET,
    OP_TRQ,
    OP_TSUB,
    OP_K1,
    OP_K2,
    OP_K4,
    OP_XUP,
    OP_DIV,
    OP_NEW
  } op_t;

  typedef enum logic [2:0] {
    MS_KB_W,
    MS_C_X,
    MS_T_INV,
    MS_K_HH,
    MS_K_H,
    MS_H_AVG,
    MS_KT_I
  } msel_t;

  typedef struct packed {
    op_t   op;
    msel_t msel;
  } uop_t;

  function automatic q_t sat33(input logic [Q_W:0] v);
    q_t r;
    if (v[Q_W] != v[Q_W-1]) begin
      r = v[Q_W] ? Q_MIN : Q_MAX;
    end else begin
      r = v[Q_W-1:0];
    end
    return r;
  endfunction

  // Q16.16 product: floor shift by 16, then clamp to 32 bits.
  function automatic q_t sat_prod(input logic [PROD_W-1:0] p);
    logic [16:0] upper;
    q_t r;
    upper = p[PROD_W-1:47];
    if ((&upper) || !(|upper)) begin
      r = p[47:16];
    end else begin
      r = p[PROD_W-1] ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

  // Step program: back-EMF, then one RK4 pass per state variable.
  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    uop_t u;
    u = '{op: OP_MUL, msel: MS_C_X};
    unique case (pc) inside
      5'd0:                    u = '{op: OP_MUL,  msel: MS_KB_W};
      5'd1:                    u = '{op: OP_VNET, msel: MS_C_X};
      5'd2, 5'd8, 5'd14, 5'd20: u = '{op: OP_MUL,  msel: MS_C_X};
      5'd3, 5'd9, 5'd15, 5'd21: u = '{op: OP_TSUB, msel: MS_C_X};
      5'd4, 5'd10, 5'd16, 5'd22: u = '{op: OP_MUL, msel: MS_T_INV};
      5'd5:                    u = '{op: OP_K1,   msel: MS_C_X};
      5'd11, 5'd17:            u = '{op: OP_K2,   msel: MS_C_X};
      5'd23:                   u = '{op: OP_K4,   msel: MS_C_X};
      5'd6, 5'd12:             u = '{op: OP_MUL,  msel: MS_K_HH};
      5'd18:                   u = '{op: OP_MUL,  msel: MS_K_H};
      5'd7, 5'd13, 5'd19:      u = '{op: OP_XUP,  msel: MS_C_X};
      5'd24:                   u = '{op: OP_DIV,  msel: MS_C_X};
      5'd25:                   u = '{op: OP_MUL,  msel: MS_H_AVG};
      5'd26:                   u = '{op: OP_NEW,  msel: MS_C_X};
      5'd27:                   u = '{op: OP_MUL,  msel: MS_KT_I};
      5'd28:                   u = '{op: OP_TRQ,  msel: MS_C_X};
      default:                 u = '{op: OP_MUL,  msel: MS_C_X};
    endcase
    return u;
  endfunction

endpackage

### design/dc_motor_rk4_step_core.sv
// DC motor step core: each accepted word is an armature voltage, and the core advances
// the stored current and speed by one fourth-order Runge-Kutta step each, in signed
// Q16.16 with saturation, returning the new speed and current as one result. One 32x32
// multiplier is reused by a 29-step program, and the divide by six of the RK4 sum runs
// seven bits per cycle. A new word is taken only once the previous one has finished,
// when the core returns to idle. A finished result waits in an output register, so a
// new word may enter while it is still pending. The user must write configuration
// registers only while the core is idle; the core itself does not enforce this.
`include "assert_macros.svh"

module dc_motor_rk4_step_core
  import dcm_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [Q_W-1:0]   in_drive_voltage,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic signed [Q_W-1:0]   out_speed,
  output logic signed [Q_W-1:0]   out_current,
  input  logic                    cfg_we,
  input  logic [2:0]              cfg_index,
  input  logic [REG_W-1:0]        cfg_wdata
);

  state_t                 state_r, state_nxt;
  logic [PC_W-1:0]        pc_r, pc_nxt;
  logic                   phase_r, phase_nxt;
  logic [DIV_CNT_W-1:0]   div_cnt_r, div_cnt_nxt;
  logic                   out_valid_r, out_valid_nxt;

  logic [REG_W-1:0] step_size_r, resistance_r, inv_induct_r, damping_r;
  logic [REG_W-1:0] inv_inertia_r, torque_const_r, back_emf_r;

  q_t current_r, speed_r;
  q_t va_r, u_r, x0_r, x_r, t_r, k_r, avg_r;
  q_t out_speed_r, out_current_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [ACC_W-1:0]         acc_r;
  logic [ACC_W-1:0]         dvd_r;
  logic [2:0]               rem_r;
  logic                     sign_r;

  uop_t uop;
  q_t   mul_a, mul_b, q, sum_x0, coef, inv, h, hh;
  logic out_busy, finish, accept;

  logic [ACC_W-1:0] div_dvd_nxt;
  logic [2:0]       div_rem_nxt;
  logic [3:0]       div_trial;

  assign uop      = uop_at(pc_r);
  assign q        = sat_prod(prod_r);
  assign sum_x0   = sat33({x0_r[Q_W-1], x0_r} + {q[Q_W-1], q});
  assign coef     = phase_r ? {1'b0, damping_r} : {1'b0, resistance_r};
  assign inv      = phase_r ? {1'b0, inv_inertia_r} : {1'b0, inv_induct_r};
  assign h        = {1'b0, step_size_r};
  assign hh       = {2'b00, step_size_r[REG_W-1:1]};
  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_busy = out_valid_r && !out_ready;
  assign finish   = (state_r == ST_RUN) && (uop.op == OP_NEW) && phase_r && !out_busy;

  assign out_valid   = out_valid_r;
  assign out_speed   = out_speed_r;
  assign out_current = out_current_r;

  always_comb begin
    mul_a = coef;
    mul_b = x_r;
    unique case (uop.msel)
      MS_KB_W: begin
        mul_a = {1'b0, back_emf_r};
        mul_b = speed_r;
      end
      MS_C_X: begin
        mul_a = coef;
        mul_b = x_r;
      end
      MS_T_INV: begin
        mul_a = t_r;
        mul_b = inv;
      end
      MS_K_HH: begin
        mul_a = k_r;
        mul_b = hh;
      end
      MS_K_H: begin
        mul_a = k_r;
        mul_b = h;
      end
      MS_H_AVG: begin
        mul_a = h;
        mul_b = avg_r;
      end
      MS_KT_I: begin
        mul_a = {1'b0, torque_const_r};
        mul_b = current_r;
      end
      default: begin
        mul_a = coef;
        mul_b = x_r;
      end
    endcase
  end

  // Restoring division by six, several quotient bits per cycle.
  always_comb begin
    div_rem_nxt = rem_r;
    div_dvd_nxt = dvd_r;
    div_trial   = '0;
    for (int b = 0; b < DIV_BITS; b++) begin
      div_trial   = {div_rem_nxt, div_dvd_nxt[ACC_W-1]};
      div_dvd_nxt = {div_dvd_nxt[ACC_W-2:0], (div_trial >= DIV_BY)};
      div_rem_nxt = (div_trial >= DIV_BY) ? 3'(div_trial - DIV_BY) : div_trial[2:0];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    pc_nxt        = pc_r;
    phase_nxt     = phase_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = (out_valid_r && out_ready) ? 1'b0 : out_valid_r;
    if (finish) begin
      out_valid_nxt = 1'b1;
    end
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_RUN;
          pc_nxt    = '0;
          phase_nxt = 1'b0;
        end
      end
      ST_RUN: begin
        unique case (uop.op)
          OP_DIV: begin
            state_nxt   = ST_DIV;
            div_cnt_nxt = '0;
            pc_nxt      = pc_r + PC_W'(1);
          end
          OP_TRQ: begin
            pc_nxt    = PC_RK_START;
            phase_nxt = 1'b1;
          end
          OP_NEW: begin
            if (!phase_r) begin
              pc_nxt = pc_r + PC_W'(1);
            end else if (!out_busy) begin
              state_nxt = ST_IDLE;
            end
          end
          default: begin
            pc_nxt = pc_r + PC_W'(1);
          end
        endcase
      end
      ST_DIV: begin
        if (div_cnt_r == DIV_CNT_W'(DIV_STEPS)) begin
          state_nxt = ST_RUN;
        end else begin
          div_cnt_nxt = div_cnt_r + DIV_CNT_W'(1);
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= ST_IDLE;
      pc_r           <= '0;
      phase_r        <= 1'b0;
      div_cnt_r      <= '0;
      out_valid_r    <= 1'b0;
      step_size_r    <= STEP_SIZE_RST;
      resistance_r   <= RESISTANCE_RST;
      inv_induct_r   <= INV_INDUCT_RST;
      damping_r      <= DAMPING_RST;
      inv_inertia_r  <= INV_INERTIA_RST;
      torque_const_r <= TORQUE_CONST_RST;
      back_emf_r     <= BACK_EMF_RST;
      current_r      <= '0;
      speed_r        <= '0;
    end else begin
      state_r     <= state_nxt;
      pc_r        <= pc_nxt;
      phase_r     <= phase_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STEP_SIZE:    step_size_r    <= cfg_wdata;
          REG_RESISTANCE:   resistance_r   <= cfg_wdata;
          REG_INV_INDUCT:   inv_induct_r   <= cfg_wdata;
          REG_DAMPING:      damping_r      <= cfg_wdata;
          REG_INV_INERTIA:  inv_inertia_r  <= cfg_wdata;
          REG_TORQUE_CONST: torque_const_r <= cfg_wdata;
          REG_BACK_EMF:     back_emf_r     <= cfg_wdata;
          default: begin
          end
        endcase
      end
      if ((state_r == ST_RUN) && (uop.op == OP_NEW)) begin
        if (!phase_r) begin
          current_r <= sum_x0;
        end else if (!out_busy) begin
          speed_r <= sum_x0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      va_r <= in_drive_voltage;
    end
    if (finish) begin
      out_speed_r   <= sum_x0;
      out_current_r <= current_r;
    end
    if (state_r == ST_RUN) begin
      case (uop.op)
        OP_MUL: begin
          prod_r <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        OP_VNET: begin
          u_r  <= sat33({va_r[Q_W-1], va_r} - {q[Q_W-1], q});
          x0_r <= current_r;
          x_r  <= current_r;
        end
        OP_TRQ: begin
          u_r  <= q;
          x0_r <= speed_r;
          x_r  <= speed_r;
        end
        OP_TSUB: begin
          t_r <= sat33({u_r[Q_W-1], u_r} - {q[Q_W-1], q});
        end
        OP_K1: begin
          k_r   <= q;
          acc_r <= {{3{q[Q_W-1]}}, q};
        end
        OP_K2: begin
          k_r   <= q;
          acc_r <= acc_r + {{2{q[Q_W-1]}}, q, 1'b0};
        end
        OP_K4: begin
          acc_r <= acc_r + {{3{q[Q_W-1]}}, q};
        end
        OP_XUP: begin
          x_r <= sum_x0;
        end
        OP_DIV: begin
          dvd_r  <= acc_r[ACC_W-1] ? (~acc_r + ACC_W'(1)) : acc_r;
          sign_r <= acc_r[ACC_W-1];
          rem_r  <= '0;
        end
        default: begin
        end
      endcase
    end
    if (state_r == ST_DIV) begin
      if (div_cnt_r != DIV_CNT_W'(DIV_STEPS)) begin
        dvd_r <= div_dvd_nxt;
        rem_r <= div_rem_nxt;
      end else begin
        avg_r <= sign_r ? (~dvd_r[Q_W-1:0] + Q_W'(1)) : dvd_r[Q_W-1:0];
      end
    end
  end

  `ASSERT_NEXT(a_start, clk, rst_n, accept, (state_r == ST_RUN) && (pc_r == '0) && !phase_r)
  `ASSERT_IMPL(a_div_cnt, clk, rst_n, state_r == ST_DIV, div_cnt_r <= DIV_CNT_W'(DIV_STEPS))
  `ASSERT_IMPL(a_out_phase, clk, rst_n, $rose(out_valid_r), $past(phase_r) && $past(state_r == ST_RUN))
  `ASSERT_IMPL(a_pc_range, clk, rst_n, state_r == ST_RUN, pc_r <= PC_LAST)

endmodule
